// ----- sv/fftr_pkg.sv -----
// shared types, constants and codes for the flash font text renderer
// no dependencies; imported by every module of the block

package fftr_pkg;

   localparam int unsigned ADDR_W      = 23;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [ADDR_W-1:0] FONT_BASE   = 23'd720896;
   localparam logic [ADDR_W-1:0] OFS_ASC32   = 23'h000806;
   localparam logic [ADDR_W-1:0] OFS_HZ16    = 23'h00280C;
   localparam logic [ADDR_W-1:0] OFS_HZ32    = 23'h042652;
   localparam logic [7:0]        HZ_FIRST    = 8'hA1;
   localparam logic [13:0]       HZ_PER_ZONE = 14'd94;
   localparam logic [7:0]        ASCII_LO    = 8'd32;
   localparam logic [7:0]        ASCII_HI    = 8'd127;

   // result kinds
   localparam logic [1:0] KIND_FETCH = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // input operations
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_ROW  = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_FONT_SIZE  = 3'd0;
   localparam logic [2:0] CSR_FG_COLOUR  = 3'd1;
   localparam logic [2:0] CSR_BG_COLOUR  = 3'd2;
   localparam logic [2:0] CSR_START_X    = 3'd3;
   localparam logic [2:0] CSR_START_Y    = 3'd4;
   localparam logic [2:0] CSR_LINE_WIDTH = 3'd5;

   typedef struct packed {
      logic        operation;
      logic [7:0]  code_first;
      logic [7:0]  code_second;
      logic        new_string;
      logic [31:0] row_bits;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] flash_address;
      logic [7:0]        byte_count;
      logic [15:0]       pixel_x;
      logic [15:0]       pixel_y;
      logic [15:0]       pixel_colour;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic        font_size;
      logic [15:0] fg_colour;
      logic [15:0] bg_colour;
      logic [15:0] start_x;
      logic [15:0] start_y;
      logic [15:0] line_width;
   } cfg_type;

   // one queued command: a single fetch/error result or a row of pixels
   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] flash_address;
      logic [7:0]        byte_count;
      logic [15:0]       pos_x;
      logic [15:0]       pos_y;
      logic [31:0]       row_bits;
      logic [5:0]        width;
   } cmd_type;

endpackage

// ----- sv/fftr_queue.sv -----
// short command queue between the front and back parts
// depends on fftr_pkg (cmd_type, queue depth)

module fftr_queue
   import fftr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    not_empty,
   output logic    full,
   output cmd_type head
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/fftr_front.sv -----
// front part: takes input items, keeps the text cursor and pending glyph,
// and turns each item into one queued command; depends on fftr_pkg

module fftr_front
   import fftr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    accept,
   input  req_type req,
   output cmd_type cmd
);

   logic [15:0] cursor_x_ff, cursor_x_in;
   logic [15:0] cursor_y_ff, cursor_y_in;
   logic [15:0] glyph_x_ff, glyph_x_in;
   logic [15:0] glyph_y_ff, glyph_y_in;
   logic [5:0]  glyph_width_ff, glyph_width_in;
   logic [5:0]  glyph_height_ff, glyph_height_in;
   logic [5:0]  row_index_ff, row_index_in;
   logic        glyph_active_ff, glyph_active_in;

   logic [15:0]       base_x, base_y, next_x;
   logic              is_ascii, bad_code, wrap;
   logic [7:0]        zone, posn;
   logic [13:0]       hz_index;
   logic [ADDR_W-1:0] address;
   logic [7:0]        count;
   logic [5:0]        w, h, row_next;
   logic [17:0]       wrap_lhs;

   always_comb begin
      base_x   = req.new_string ? cfg.start_x : cursor_x_ff;
      base_y   = req.new_string ? cfg.start_y : cursor_y_ff;
      is_ascii = (req.code_first >= ASCII_LO) && (req.code_first <= ASCII_HI);
      bad_code = !is_ascii && ((req.code_first < HZ_FIRST) || (req.code_first < HZ_FIRST
                 ) || (req.code_second < HZ_FIRST));
      zone     = req.code_first - HZ_FIRST;
      posn     = req.code_second - HZ_FIRST;
      hz_index = 14'(zone[6:0]) * HZ_PER_ZONE + 14'(posn[6:0]);

      if (is_ascii) begin
         if (cfg.font_size) begin
            address = FONT_BASE + OFS_ASC32 + {9'd0, req.code_first, 6'd0};
            count   = 8'd64;
            w       = 6'd16;
            h       = 6'd32;
         end else begin
            address = FONT_BASE + {11'd0, req.code_first, 4'd0};
            count   = 8'd16;
            w       = 6'd8;
            h       = 6'd16;
         end
      end else begin
         if (cfg.font_size) begin
            address = FONT_BASE + OFS_HZ32 + {2'd0, hz_index, 7'd0};
            count   = 8'd128;
            w       = 6'd32;
            h       = 6'd32;
         end else begin
            address = FONT_BASE + OFS_HZ16 + {4'd0, hz_index, 5'd0};
            count   = 8'd32;
            w       = 6'd16;
            h       = 6'd16;
         end
      end

      // signed test x > width-1-w rewritten as x+1+w > width, all terms non-negative
      next_x   = base_x + 16'(w);
      wrap_lhs = {2'd0, next_x} + 18'd1 + 18'(w);
      wrap     = wrap_lhs > {2'd0, cfg.line_width};
      row_next = row_index_ff + 6'd1;
   end

   always_comb begin
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      glyph_x_in      = glyph_x_ff;
      glyph_y_in      = glyph_y_ff;
      glyph_width_in  = glyph_width_ff;
      glyph_height_in = glyph_height_ff;
      row_index_in    = row_index_ff;
      glyph_active_in = glyph_active_ff;

      cmd               = '0;
      cmd.kind          = KIND_ERROR;

      if (req.operation == OP_CHAR) begin
         cursor_x_in = base_x;
         cursor_y_in = base_y;
         if (bad_code) begin
            glyph_active_in = 1'b0;
         end else begin
            glyph_x_in        = base_x;
            glyph_y_in        = base_y;
            glyph_width_in    = w;
            glyph_height_in   = h;
            row_index_in      = '0;
            glyph_active_in   = 1'b1;
            cmd.kind          = KIND_FETCH;
            cmd.flash_address = address;
            cmd.byte_count    = count;
            cmd.pos_x         = base_x;
            cmd.pos_y         = base_y;
            cursor_x_in       = wrap ? 16'd0 : next_x;
            cursor_y_in       = wrap ? base_y + 16'(h) : base_y;
         end
      end else if (glyph_active_ff) begin
         cmd.kind     = KIND_PIXEL;
         cmd.pos_x    = glyph_x_ff;
         cmd.pos_y    = glyph_y_ff + 16'(row_index_ff);
         cmd.row_bits = req.row_bits;
         cmd.width    = glyph_width_ff;
         row_index_in = row_next;
         if (row_next >= glyph_height_ff) begin
            glyph_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         glyph_x_ff      <= '0;
         glyph_y_ff      <= '0;
         glyph_width_ff  <= '0;
         glyph_height_ff <= '0;
         row_index_ff    <= '0;
         glyph_active_ff <= 1'b0;
      end else if (accept) begin
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         glyph_x_ff      <= glyph_x_in;
         glyph_y_ff      <= glyph_y_in;
         glyph_width_ff  <= glyph_width_in;
         glyph_height_ff <= glyph_height_in;
         row_index_ff    <= row_index_in;
         glyph_active_ff <= glyph_active_in;
      end
   end

endmodule

// ----- sv/fftr_back.sv -----
// back part: takes commands from the queue and drives the result register,
// one result per cycle while a command is queued and rsp_stall is low; depends on fftr_pkg

module fftr_back
   import fftr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [4:0]  col_ff, col_in;
   logic        load, end_of_cmd, bit_set;
   logic [4:0]  bit_sel;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      load       = !rsp_valid_ff || !rsp_stall;
      bit_sel    = 5'(cmd.width - 6'd1 - {1'b0, col_ff});
      bit_set    = cmd.row_bits[bit_sel];
      end_of_cmd = (cmd.kind != KIND_PIXEL) || ({1'b0, col_ff} + 6'd1 == cmd.width);
      cmd_pop    = load && cmd_valid && end_of_cmd;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      col_in       = col_ff;
      if (load) begin
         rsp_valid_in = cmd_valid;
         rsp_data_in  = '0;
         rsp_data_in.kind = cmd.kind;
         rsp_data_in.last = end_of_cmd;
         case (cmd.kind)
            KIND_FETCH: begin
               rsp_data_in.flash_address = cmd.flash_address;
               rsp_data_in.byte_count    = cmd.byte_count;
               rsp_data_in.pixel_x       = cmd.pos_x;
               rsp_data_in.pixel_y       = cmd.pos_y;
            end
            KIND_PIXEL: begin
               rsp_data_in.pixel_x      = cmd.pos_x + 16'(col_ff);
               rsp_data_in.pixel_y      = cmd.pos_y;
               rsp_data_in.pixel_colour = bit_set ? cfg.fg_colour : cfg.bg_colour;
            end
            default: begin
            end
         endcase
         if (cmd_valid) begin
            col_in = end_of_cmd ? 5'd0 : col_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- sv/flash_font_text_renderer.sv -----
// top level of the flash font text renderer: register file and the
// front, queue and back parts; depends on fftr_pkg, fftr_front, fftr_queue, fftr_back

// A character item (operation 0) gives one result, a flash fetch request with
// the glyph's address, byte count and screen position, or an error for a bad
// GB2312 code; a valid code also moves the text cursor. A row item (operation 1)
// gives one pixel result per glyph column (8, 16 or 32), the last one marked,
// or a single error when no glyph is pending. The front takes one item per
// cycle while the four-entry command queue has room; the back emits exactly
// one result per cycle while a command is queued and rsp_stall is low.
// Register writes are always taken (csr_ready is tied high) and must only be
// made while the block is idle.

module flash_font_text_renderer
   import fftr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   cmd_type front_cmd, queue_head;
   logic    req_accept, queue_full, queue_not_empty, queue_pop;

   assign csr_ready  = 1'b1;
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FONT_SIZE:  cfg_in.font_size  = csr_data[0];
            CSR_FG_COLOUR:  cfg_in.fg_colour  = csr_data;
            CSR_BG_COLOUR:  cfg_in.bg_colour  = csr_data;
            CSR_START_X:    cfg_in.start_x    = csr_data;
            CSR_START_Y:    cfg_in.start_y    = csr_data;
            CSR_LINE_WIDTH: cfg_in.line_width = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.font_size  <= 1'b0;
         cfg_ff.fg_colour  <= 16'h0000;
         cfg_ff.bg_colour  <= 16'hFFFF;
         cfg_ff.start_x    <= '0;
         cfg_ff.start_y    <= '0;
         cfg_ff.line_width <= 16'd320;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fftr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (req_accept),
      .req    (req_data),
      .cmd    (front_cmd)
   );

   fftr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_cmd),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .full      (queue_full),
      .head      (queue_head)
   );

   fftr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (queue_not_empty),
      .cmd       (queue_head),
      .cmd_pop   (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/fftr_checker.sv -----
// port-level checks for the flash font text renderer, bound to the top level
// depends on fftr_pkg

module fftr_checker
   import fftr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // fetch and error results stand alone, so they always close their item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_PIXEL |-> rsp_data.last)
      else $error("fetch or error not marked last");

   a_pixel_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_FETCH |->
         rsp_data.flash_address == '0 && rsp_data.byte_count == '0)
      else $error("address fields set outside a fetch");

endmodule

bind flash_font_text_renderer fftr_checker u_fftr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- bench/render_checker.sv -----
// result checker for the flash font text renderer: follows the register,
// character and row transfers, predicts every result and compares in order
// depends on fftr_pkg for the transfer types and the kind, operation and register codes

module render_checker
   import fftr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int unsigned fail_count,
   output int unsigned results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // font flash layout
   localparam int FONT_ORIGIN    = 720896;
   localparam int ASCII_WIDE_OFS = 'h806;
   localparam int HANZI16_OFS    = 'h280C;
   localparam int HANZI32_OFS    = 'h42652;
   localparam int HANZI_FIRST    = 161;
   localparam int ZONE_SPAN      = 94;
   localparam int ASCII_FIRST    = 32;
   localparam int ASCII_LAST     = 127;

   cfg_type     regs;
   logic [15:0] cur_x, cur_y, glyph_x, glyph_y;
   logic [5:0]  glyph_w, glyph_h, row_idx;
   logic        glyph_busy;
   rsp_type     results_due[$];
   int unsigned failures = 0;

   assign fail_count = failures;

   task automatic clear_model();
      regs.font_size  = 1'b0;
      regs.fg_colour  = 16'h0000;
      regs.bg_colour  = 16'hFFFF;
      regs.start_x    = 16'd0;
      regs.start_y    = 16'd0;
      regs.line_width = 16'd320;
      cur_x      = '0;
      cur_y      = '0;
      glyph_x    = '0;
      glyph_y    = '0;
      glyph_w    = '0;
      glyph_h    = '0;
      row_idx    = '0;
      glyph_busy = 1'b0;
      results_due.delete();
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
      case (idx)
         CSR_FONT_SIZE:  regs.font_size  = value[0];
         CSR_FG_COLOUR:  regs.fg_colour  = value;
         CSR_BG_COLOUR:  regs.bg_colour  = value;
         CSR_START_X:    regs.start_x    = value;
         CSR_START_Y:    regs.start_y    = value;
         CSR_LINE_WIDTH: regs.line_width = value;
         default: ;
      endcase
   endtask

   // fetch request, or an error for a bad code, for one character, then the cursor step
   task automatic predict_char(input req_type item);
      rsp_type    r;
      int         addr;
      int         glyph_no;
      int         wrap_limit;
      logic [7:0] count;
      logic [5:0] w, h;
      logic       bad_code;
      r        = '0;
      r.last   = 1'b1;
      bad_code = 1'b0;
      addr     = 0;
      count    = '0;
      w        = '0;
      h        = '0;
      if (item.new_string) begin
         cur_x = regs.start_x;
         cur_y = regs.start_y;
      end
      if (int'(item.code_first) >= ASCII_FIRST && int'(item.code_first) <= ASCII_LAST) begin
         if (regs.font_size) begin
            addr  = FONT_ORIGIN + ASCII_WIDE_OFS + int'(item.code_first) * 64;
            count = 8'd64;
            w     = 6'd16;
            h     = 6'd32;
         end else begin
            addr  = FONT_ORIGIN + int'(item.code_first) * 16;
            count = 8'd16;
            w     = 6'd8;
            h     = 6'd16;
         end
      end else if (int'(item.code_first) < HANZI_FIRST ||
                   int'(item.code_second) < HANZI_FIRST) begin
         bad_code = 1'b1;
      end else begin
         glyph_no = (int'(item.code_first) - HANZI_FIRST) * ZONE_SPAN +
                    (int'(item.code_second) - HANZI_FIRST);
         if (regs.font_size) begin
            addr  = FONT_ORIGIN + HANZI32_OFS + glyph_no * 128;
            count = 8'd128;
            w     = 6'd32;
            h     = 6'd32;
         end else begin
            addr  = FONT_ORIGIN + HANZI16_OFS + glyph_no * 32;
            count = 8'd32;
            w     = 6'd16;
            h     = 6'd16;
         end
      end
      if (bad_code) begin
         glyph_busy = 1'b0;
         r.kind     = KIND_ERROR;
         results_due.push_back(r);
      end else begin
         glyph_x    = cur_x;
         glyph_y    = cur_y;
         glyph_w    = w;
         glyph_h    = h;
         row_idx    = '0;
         glyph_busy = 1'b1;
         r.kind          = KIND_FETCH;
         r.flash_address = addr[22:0];
         r.byte_count    = count;
         r.pixel_x       = glyph_x;
         r.pixel_y       = glyph_y;
         results_due.push_back(r);
         // signed wrap test, so a narrow line wraps every glyph
         cur_x      = cur_x + {10'd0, w};
         wrap_limit = int'(regs.line_width) - 1 - int'(w);
         if (int'(cur_x) > wrap_limit) begin
            cur_x = '0;
            cur_y = cur_y + {10'd0, h};
         end
      end
   endtask

   task automatic predict_row(input req_type item);
      rsp_type     r;
      logic [15:0] py;
      int          j;
      if (!glyph_busy || glyph_w == 0 || glyph_w > 32) begin
         r      = '0;
         r.kind = KIND_ERROR;
         r.last = 1'b1;
         results_due.push_back(r);
      end else begin
         py = glyph_y + {10'd0, row_idx};
         for (j = 0; j < int'(glyph_w); j++) begin
            r              = '0;
            r.kind         = KIND_PIXEL;
            r.pixel_x      = glyph_x + 16'(j);
            r.pixel_y      = py;
            r.pixel_colour = item.row_bits[int'(glyph_w) - 1 - j] ? regs.fg_colour
                                                                  : regs.bg_colour;
            r.last         = (j + 1 == int'(glyph_w));
            results_due.push_back(r);
         end
         row_idx = row_idx + 6'd1;
         if (row_idx >= glyph_h) glyph_busy = 1'b0;
      end
   endtask

   task automatic compare_field(input string field_name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field_name, want, got);
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (results_due.size() == 0) begin
         failures++;
         $display("%0t: result with nothing outstanding, expected none actual %h", $time, got);
      end else begin
         want = results_due.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("flash_address", 32'(want.flash_address), 32'(got.flash_address));
         compare_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
         compare_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
         compare_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
         compare_field("pixel_colour", 32'(want.pixel_colour), 32'(got.pixel_colour));
         compare_field("last", 32'(want.last), 32'(got.last));
      end
   endtask

   // a character or row transfer is predicted before a result of the same edge is checked
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_valid && csr_ready) write_register(csr_index, csr_data);
         if (req_valid && !req_stall) begin
            if (req_data.operation == OP_CHAR) predict_char(req_data);
            else predict_row(req_data);
         end
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      results_owed = results_due.size();
   end

endmodule

// ----- bench/flash_font_text_renderer_tb.sv -----
// testbench top for the flash font text renderer: clock, reset, character and
// row stimulus, register settings and back-pressure; verdict from render_checker
// depends on fftr_pkg, render_checker and flash_font_text_renderer

module flash_font_text_renderer_tb
   import fftr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int          PHASES      = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_FONT_SIZE;
   logic [15:0] csr_data = '0;

   int unsigned fail_count;
   int unsigned results_owed;
   int unsigned sent = 0;
   logic        calm = 1'b0;
   logic        send_gaps = 1'b1;
   logic        big_font = 1'b0;

   flash_font_text_renderer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   render_checker render_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // pixel sink back-pressure in bursts, with stretches of none
   initial begin : pixel_sink
      int unsigned burst;
      logic        stall_mode;
      burst      = 0;
      stall_mode = 1'b1;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) == 0) stall_mode = !stall_mode;
         if (burst == 0 && stall_mode && $urandom_range(0, 5) == 0)
            burst = $urandom_range(1, 7);
         if (calm || burst == 0) begin
            rsp_stall <= 1'b0;
            burst = 0;
         end else begin
            rsp_stall <= 1'b1;
            burst--;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_item(input req_type item);
      int unsigned gap;
      if ($urandom_range(0, 31) == 0) send_gaps = !send_gaps;
      if (!calm && send_gaps && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // stop sending until every outstanding result has been taken
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_registers(input logic font, input logic [15:0] fg,
                                    input logic [15:0] bg, input logic [15:0] sx,
                                    input logic [15:0] sy, input logic [15:0] lw);
      drain();
      repeat (6) @(negedge clock);
      write_csr(CSR_FONT_SIZE, {15'd0, font});
      write_csr(CSR_FG_COLOUR, fg);
      write_csr(CSR_BG_COLOUR, bg);
      write_csr(CSR_START_X, sx);
      write_csr(CSR_START_Y, sy);
      write_csr(CSR_LINE_WIDTH, lw);
      @(negedge clock);
      csr_valid <= 1'b0;
      big_font = font;
   endtask

   function automatic req_type char_item(input logic [7:0] c1, input logic [7:0] c2,
                                         input logic ns);
      req_type item;
      item.operation   = OP_CHAR;
      item.code_first  = c1;
      item.code_second = c2;
      item.new_string  = ns;
      item.row_bits    = $urandom();
      return item;
   endfunction

   function automatic req_type row_item(input logic [31:0] bits);
      req_type item;
      item.operation   = OP_ROW;
      item.code_first  = 8'($urandom_range(0, 255));
      item.code_second = 8'($urandom_range(0, 255));
      item.new_string  = 1'($urandom_range(0, 1));
      item.row_bits    = bits;
      return item;
   endfunction

   // an ASCII code from 32 to 127 or a valid hanzi character followed by its rows,
   // sometimes cut short or followed by one row too many
   task automatic glyph_sequence();
      req_type     item;
      int unsigned rows;
      int unsigned shape;
      int unsigned k;
      shape = $urandom_range(0, 9);
      if ($urandom_range(0, 1))
         item = char_item(8'($urandom_range(32, 127)), 8'($urandom_range(0, 255)),
                          $urandom_range(0, 7) == 0);
      else
         item = char_item(8'($urandom_range(161, 255)), 8'($urandom_range(161, 255)),
                          $urandom_range(0, 7) == 0);
      rows = big_font ? 32 : 16;
      if (shape == 0) rows = $urandom_range(0, rows - 1);
      if (shape == 1) rows++;
      send_item(item);
      for (k = 0; k < rows; k++) send_item(row_item($urandom()));
   endtask

   task automatic noise_item();
      req_type item;
      item.operation   = 1'($urandom_range(0, 1));
      item.code_first  = 8'($urandom_range(0, 255));
      item.code_second = 8'($urandom_range(0, 255));
      item.new_string  = 1'($urandom_range(0, 1));
      item.row_bits    = $urandom();
      send_item(item);
   endtask

   initial begin : stimulus
      int unsigned target;
      int unsigned pick;
      logic [15:0] lw;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed part under the reset settings
      send_item(row_item($urandom()));               // row with nothing pending
      send_item(char_item(8'd32, 8'hFF, 1'b1));
      send_item(row_item(32'hFFFF_FFFF));            // bits above the width ignored
      send_item(row_item(32'h0000_0000));
      send_item(char_item(8'd127, 8'h00, 1'b0));     // replaces the pending glyph
      send_item(row_item(32'h0000_00A5));
      send_item(char_item(8'hA1, 8'hA1, 1'b0));
      send_item(row_item(32'hFFFF_8001));
      send_item(char_item(8'hFF, 8'hFF, 1'b1));
      send_item(row_item($urandom()));
      send_item(char_item(8'hA0, 8'hC0, 1'b0));      // bad zone byte
      send_item(row_item($urandom()));               // glyph dropped by the bad code
      send_item(char_item(8'hB0, 8'hA0, 1'b0));      // bad position byte
      send_item(char_item(8'h00, 8'hFF, 1'b1));
      send_item(char_item(8'd31, 8'h00, 1'b0));
      send_item(char_item(8'd128, 8'hA1, 1'b0));
      send_item(char_item(8'hA1, 8'h00, 1'b1));

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: program_registers(1'b1, 16'hFFFF, 16'h0000, 16'd0, 16'd0, 16'd33);
            1: program_registers(1'b0, 16'($urandom()), 16'($urandom()), 16'hFFFF,
                                 16'hFFFF, 16'hFFFF);
            2: program_registers(1'b1, 16'h0000, 16'hFFFF, 16'd100, 16'd200, 16'd0);
            default: begin
               pick = $urandom_range(0, 3);
               if (pick == 0) lw = 16'($urandom_range(0, 32));
               else if (pick == 1) lw = 16'($urandom());
               else lw = 16'($urandom_range(33, 400));
               program_registers(1'($urandom_range(0, 1)), 16'($urandom()),
                                 16'($urandom()),
                                 ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                             : 16'($urandom_range(0, 300)),
                                 ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                             : 16'($urandom_range(0, 300)),
                                 lw);
            end
         endcase
         if (phase == 0) begin
            // wide font extremes
            send_item(char_item(8'd32, 8'h00, 1'b1));
            send_item(char_item(8'd127, 8'h00, 1'b0));
            send_item(char_item(8'hA1, 8'hA1, 1'b0));
            send_item(char_item(8'hFF, 8'hFF, 1'b0));
         end
         if (phase == PHASES - 1) calm = 1'b1;
         target = sent + 45;
         while (sent < target) begin
            if ($urandom_range(0, 3) == 0) noise_item();
            else glyph_sequence();
            if ($urandom_range(0, 24) == 0) drain();
         end
      end

      drain();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && results_owed == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
sv/fftr_pkg.sv
sv/fftr_queue.sv
sv/fftr_front.sv
sv/fftr_back.sv
sv/flash_font_text_renderer.sv
sv/fftr_checker.sv
bench/render_checker.sv
bench/flash_font_text_renderer_tb.sv
